// ----- rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Shared types, constants and the character-to-sextet mapping.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] UPPER_LO   = 8'h41;
    localparam logic [7:0] UPPER_HI   = 8'h5A;
    localparam logic [7:0] LOWER_LO   = 8'h61;
    localparam logic [7:0] LOWER_HI   = 8'h7A;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;
    localparam logic [7:0] PUNCT_LO   = 8'h2B;
    localparam logic [7:0] PUNCT_HI   = 8'h2F;
    // Lowercase maps to c - 'a' + 26, which is c - 71 modulo 64.
    localparam logic [7:0] LOWER_OFS  = 8'd71;
    // Digits map to c - '0' + 52, which is c + 4 modulo 64.
    localparam logic [7:0] DIGIT_OFS  = 8'd4;

    // Sextets for '+', ',', '-', '.', '/'.
    localparam logic [5:0] PUNCT_SEXTET [5] = '{6'd62, 6'd63, 6'd62, 6'd62, 6'd63};

    // One decoded group: up to three bytes, most significant first.
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  nbytes;
    } t_group;

    // Fill status of the output queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic       in_alpha;
        logic       is_pad;
        logic [5:0] sextet;
    } t_char_map;

    function automatic t_char_map map_char(input logic [7:0] c);
        t_char_map m;
        logic [7:0] d;
        m = '{in_alpha: 1'b1, is_pad: 1'b0, sextet: 6'd0};
        d = 8'd0;
        priority if (c == PAD_CHAR) begin
            m.is_pad = 1'b1;
        end else if (c >= UPPER_LO && c <= UPPER_HI) begin
            d = c - UPPER_LO;
            m.sextet = d[5:0];
        end else if (c >= LOWER_LO && c <= LOWER_HI) begin
            d = c - LOWER_OFS;
            m.sextet = d[5:0];
        end else if (c >= DIGIT_LO && c <= DIGIT_HI) begin
            d = c + DIGIT_OFS;
            m.sextet = d[5:0];
        end else if (c >= PUNCT_LO && c <= PUNCT_HI) begin
            d = c - PUNCT_LO;
            m.sextet = PUNCT_SEXTET[d[2:0]];
        end else begin
            m.in_alpha = 1'b0;
        end
        return m;
    endfunction

endpackage

// ----- rtl/b64d_group.sv -----
// ----------------------------------------------------------------------------
// Base64 group assembler
// Collects sextets into groups of four and produces a decoded group on a
// full group or on the end-of-text flush.
// ----------------------------------------------------------------------------
module b64d_group
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_end,
    output t_group     o_grp
);

    logic [17:0] r_held, n_held;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_tpad, n_tpad;
    t_char_map   cmap;

    always_comb begin
        cmap   = map_char(i_char);
        n_held = r_held;
        n_cnt  = r_cnt;
        n_tpad = r_tpad;
        o_grp  = '{triple: 24'd0, nbytes: 2'd0};

        if (cmap.in_alpha) begin
            if (r_cnt == 2'd3) begin
                o_grp.triple = {r_held, cmap.sextet};
                if (cmap.is_pad) begin
                    o_grp.nbytes = r_tpad ? 2'd1 : 2'd2;
                end else begin
                    o_grp.nbytes = 2'd3;
                end
                n_held = 18'd0;
                n_cnt  = 2'd0;
                n_tpad = 1'b0;
            end else begin
                n_held = {r_held[11:0], cmap.sextet};
                if (r_cnt == 2'd2) begin
                    n_tpad = cmap.is_pad;
                end
                n_cnt = r_cnt + 2'd1;
            end
        end

        // The end flag flushes whatever partial group is open, zero filled.
        if (i_end) begin
            unique case (n_cnt)
                2'd1: begin
                    o_grp = '{triple: {n_held[5:0], 18'd0}, nbytes: 2'd0};
                end
                2'd2: begin
                    o_grp = '{triple: {n_held[11:0], 12'd0}, nbytes: 2'd1};
                end
                2'd3: begin
                    o_grp = '{triple: {n_held, 6'd0}, nbytes: n_tpad ? 2'd1 : 2'd2};
                end
                default: begin
                end
            endcase
            n_held = 18'd0;
            n_cnt  = 2'd0;
            n_tpad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 18'd0;
            r_cnt  <= 2'd0;
            r_tpad <= 1'b0;
        end else if (i_step) begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
            r_tpad <= n_tpad;
        end
    end

endmodule

// ----- rtl/b64d_outq.sv -----
// ----------------------------------------------------------------------------
// Base64 output queue
// Buffers decoded groups and hands them out one byte per transaction.
// ----------------------------------------------------------------------------
module b64d_outq
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_group     i_grp,
    output t_q_status  o_status,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_group        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_bidx;
    t_group        head;
    logic          pop_byte, pop_grp;

    assign head       = r_mem[r_rd_ptr];
    assign o_valid    = (r_count != '0);
    assign o_run_last = (r_bidx == head.nbytes - 2'd1);
    assign pop_byte   = o_valid && i_ready;
    assign pop_grp    = pop_byte && o_run_last;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

    always_comb begin
        unique case (r_bidx)
            2'd0:    o_out_byte = head.triple[23:16];
            2'd1:    o_out_byte = head.triple[15:8];
            default: o_out_byte = head.triple[7:0];
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !pop_grp) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && pop_grp) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_bidx   <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop_grp) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
                r_bidx   <= 2'd0;
            end else if (pop_byte) begin
                r_bidx <= r_bidx + 2'd1;
            end
        end
    end

endmodule

// ----- rtl/base64_stream_decoder.sv -----
// Path: a character accepted into the input register is decoded as it leaves it,
// and its group goes to the output queue. Groups are queued in Q_DEPTH entries.
// Throughput: one character per cycle in while the queue is not full; one byte per
// cycle out while i_ready is high, set by the single output byte lane.
// Reset: synchronous active-low reset empties the queue and clears the open group.
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a stream of text characters with a permissive base64 alphabet
// into bytes, with trailing pad handling and an end-of-text flush.
// ----------------------------------------------------------------------------
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int Q_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_text_char,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    // Input register: holds one character transaction until the queue has
    // room for whatever group it may produce.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_end;

    t_group     grp;
    t_q_status  q_status;
    logic       advance;
    logic       push;

    // A registered character is decoded in the cycle it leaves the input
    // register; that needs one free queue entry, since a character makes at
    // most one group.
    assign advance = r_in_valid && !q_status.full;
    assign o_ready = !r_in_valid || !q_status.full;
    assign push    = advance && (grp.nbytes != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_text_char;
            r_end  <= i_end_of_text;
        end
    end

    // Sextet mapping and group assembly; the group state only moves when the
    // registered character is actually consumed.
    b64d_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_char  (r_char),
        .i_end   (r_end),
        .o_grp   (grp)
    );

    // Group queue and byte serializer. Every byte of one group is decoded from the
    // same group of input characters, so the last byte of a group carries run_last.
    b64d_outq #(
        .DEPTH (Q_DEPTH)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_grp      (grp),
        .o_status   (q_status),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

    // The queue can never be both full and empty.
    a_q_status_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("output queue reports full and empty together");

    // Output valid follows queue occupancy.
    a_valid_matches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == !q_status.empty)
        else $error("output valid disagrees with queue occupancy");

    // A character stalled by a full queue stays in the input register.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && q_status.full) |=> (r_in_valid && $stable(r_char)))
        else $error("stalled character was lost");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule
